### hw/rtl/egse_pkg.sv
package egse_pkg;

  // Input word: one encode or flush request
  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
  } in_word_t;

  // Output word: one packed code byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

  // Operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam int unsigned BYTE_BITS = 8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the mapped code of the accepted word
    logic find;   // locate the leading one of the code
    logic align;  // normalise the code and set the bit counters
    logic step;   // pack one chunk of bits, possibly emitting a byte
    logic flush;  // emit the partial byte padded with zeros
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic space;     // output register free, or freed this cycle
    logic rem_zero;  // no code bits left to pack
    logic cnt_nz;    // a partial byte is pending
  } ctrl_sts_t;

endpackage

### hw/rtl/egse_ctrl.sv
module egse_ctrl import egse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  output logic       in_ready_o,
  input  ctrl_sts_t  sts_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_op_i == OP_FLUSH) ? S_FLUSH : S_FIND;
        end
      end
      S_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = S_ALIGN;
      end
      S_ALIGN: begin
        cmd_o.align = 1'b1;
        state_d     = S_RUN;
      end
      S_RUN: begin
        if (sts_i.rem_zero) begin
          state_d = S_IDLE;
        end else if (sts_i.space) begin
          cmd_o.step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!sts_i.cnt_nz) begin
          state_d = S_IDLE;
        end else if (sts_i.space) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/egse_datapath.sv
module egse_datapath import egse_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_word_t   in_data_i,
  input  ctrl_cmd_t  cmd_i,
  output ctrl_sts_t  sts_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_data_o
);

  localparam int unsigned CW = VALUE_BITS + 1;
  localparam int unsigned LW = $clog2(VALUE_BITS + 2);
  localparam int unsigned RW = $clog2(2 * VALUE_BITS + 2);

  logic [CW-1:0] code_q, code_d;
  logic [CW-1:0] norm_q, norm_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] zl_q, zl_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [6:0]    acc_q, acc_d;
  logic [2:0]    cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_q, out_d;

  logic [VALUE_BITS-1:0] v;
  logic [CW-1:0]         mag;
  logic [3:0]            need, take, sum_cnt;
  logic [RW-1:0]         avail, rem_new;
  logic [7:0]            src;
  logic [15:0]           merged;
  logic [7:0]            flush_byte;
  logic                  zero_phase, emit_step, emit;

  // Map signed to positive code in VALUE_BITS+1 bits
  assign v   = in_data_i.value[VALUE_BITS-1:0];
  assign mag = {1'b1, {VALUE_BITS{1'b0}}} - {1'b0, v};

  always_comb begin
    if (v[VALUE_BITS-1]) begin
      code_d = {mag[VALUE_BITS-1:0], 1'b0};
    end else begin
      code_d = {v, 1'b1};
    end
  end

  // Leading one position
  always_comb begin
    len_d = '0;
    for (int i = 0; i < CW; i++) begin
      if (code_q[i]) begin
        len_d = LW'(i + 1);
      end
    end
  end

  // Packing step: zeros first, then the code bits MSB first
  assign zero_phase = (zl_q != '0);
  assign need       = 4'd8 - {1'b0, cnt_q};
  assign avail      = zero_phase ? RW'(zl_q) : rem_q;
  assign take       = (avail < RW'(need)) ? 4'(avail) : need;
  assign src        = zero_phase ? 8'd0 : norm_q[CW-1 -: 8];
  assign merged     = (16'(acc_q) << take) | 16'(src >> (4'd8 - take));
  assign sum_cnt    = {1'b0, cnt_q} + take;
  assign emit_step  = (sum_cnt == 4'd8);
  assign rem_new    = rem_q - RW'(take);
  assign flush_byte = 8'(16'(acc_q) << (4'd8 - {1'b0, cnt_q}));
  assign emit       = (cmd_i.step && emit_step) || (cmd_i.flush && cnt_q != '0);

  always_comb begin
    norm_d      = norm_q;
    zl_d        = zl_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.align) begin
      norm_d = code_q << (LW'(CW) - len_q);
      zl_d   = len_q - LW'(1);
      rem_d  = RW'({len_q, 1'b0}) - RW'(1);
    end
    if (cmd_i.step) begin
      rem_d = rem_new;
      if (zero_phase) begin
        zl_d = zl_q - LW'(take);
      end else begin
        norm_d = norm_q << take;
      end
      if (emit_step) begin
        acc_d          = '0;
        cnt_d          = '0;
        out_d.out_byte = merged[7:0];
        out_d.last     = (rem_new < RW'(BYTE_BITS));
        out_valid_d    = 1'b1;
      end else begin
        acc_d = merged[6:0];
        cnt_d = sum_cnt[2:0];
      end
    end
    if (cmd_i.flush && cnt_q != '0) begin
      acc_d          = '0;
      cnt_d          = '0;
      out_d.out_byte = flush_byte;
      out_d.last     = 1'b1;
      out_valid_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zl_q        <= '0;
      rem_q       <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      zl_q        <= zl_d;
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= code_d;
    end
    if (cmd_i.find) begin
      len_q <= len_d;
    end
    norm_q <= norm_d;
    out_q  <= out_d;
  end

  assign sts_o.space    = !out_valid_q || out_ready_i;
  assign sts_o.rem_zero = (rem_q == '0);
  assign sts_o.cnt_nz   = (cnt_q != '0);
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  // Never overwrite a byte still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("byte emitted over an untaken byte");

  // Leading zeros are used up before the code bits run out
  a_zeros_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == '0) |-> (zl_q == '0))
    else $error("zero run outlives remaining bits");

  // A flush leaves nothing pending
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> (cnt_q == '0))
    else $error("partial byte survives a flush");

endmodule

### hw/rtl/elias_gamma_signed_encoder.sv
// Signed Elias gamma encoder with a byte packer. Each input word either
// encodes a signed value (operation 0) or flushes the partial byte
// (operation 1). A value x maps to -2x when negative and to 2x+1 otherwise,
// worked in VALUE_BITS+1 bits so the most negative value is still coded;
// the code of length L is sent as L-1 zeros and then its L bits, MSB first,
// packed MSB first into bytes. A byte leaves as soon as eight bits are
// gathered, and last marks the final byte caused by an input word. A flush
// pads pending bits with zeros at the low end; with nothing pending it
// produces no byte. Sequence: a word is taken in the idle state, then an
// encode finds the leading one, normalises the code and runs one packing
// step per cycle while the output register has room - each step either
// completes a byte or ends the zero run or the code - and then returns to
// idle; a 32-bit value gives up to nine bytes. A flush goes from idle to
// the flush state and back. The single packing step, gated by the one-word
// output register, sets the pace; a finished byte waits in that register
// while the next word is already being worked on.
module elias_gamma_signed_encoder import egse_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence the load, leading-one search, normalise, pack and flush steps
  egse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the code, bit counters, pending byte and output register
  egse_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
